/* src/periodic_timeout_table_defines.svh */
// Assertion macros for the periodic timeout table RTL.
// Depends on signals named clk and arst_n in the including module.
`ifndef PERIODIC_TIMEOUT_TABLE_DEFINES_SVH
`define PERIODIC_TIMEOUT_TABLE_DEFINES_SVH

// Checked on every rising edge, masked while reset is asserted
`define PTT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define PTT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ptt_pkg.sv */
// Shared types and constants for the periodic timeout table.
// Used by ptt_slot_store and periodic_timeout_table; no dependencies.
package ptt_pkg;

	// Table size and derived index width
	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Stream widths
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 40;

	// Operation codes
	localparam logic [1:0] OP_INIT    = 2'd0;
	localparam logic [1:0] OP_POLL    = 2'd1;
	localparam logic [1:0] OP_GET_MIN = 2'd2;

	// Answer of get-min when no slot is in use
	localparam logic [31:0] NONE_USED = 32'hffff_ffff;

	// One table entry
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] period;
		logic        used;
	} slot_t;

	// Write port request
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_t             entry;
	} wr_req_t;

	// Table-wide restart request
	typedef struct packed {
		logic        en;
		logic [31:0] tick;
	} clr_req_t;

endpackage

/* src/periodic_timeout_table.sv */
// Periodic timeout table: SLOT_COUNT timer slots (start, period, used) held
// in a synchronous table with a registered read. One transaction is
// handled at a time. Init restarts every slot at once through per-slot valid
// bits; from acceptance it goes straight to the response step, which
// registers its result, and the next transaction is taken after that. Poll
// reads, updates and writes back its slot in the poll step, then goes to the
// response step. Get-min reads one slot per cycle from the single table read
// port in the scan step, over all SLOT_COUNT slots, then goes to the response
// step. Unknown operations answer zero and follow the path of init.
// The result sits in an output register; a stalled result only holds the
// block in its response step, and the next transaction is taken once the
// result has moved there.
// Depends on ptt_pkg, ptt_slot_store and periodic_timeout_table_defines.svh.
`include "periodic_timeout_table_defines.svh"

module periodic_timeout_table (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: operation[1:0], slot_id[4:2], period[36:5], tick_time[68:37], zero fill
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ptt_pkg::IN_TDATA_W-1:0]    s_tdata,
	// m_tdata: timed_out[0], min_remaining[32:1], zero fill
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ptt_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	typedef enum logic [1:0] {ST_IDLE, ST_POLL, ST_SCAN, ST_RESP} state_t;

	state_t                       state_q;
	logic [ptt_pkg::SLOT_W-1:0]   slot_idx_s1;
	logic                         slot_ok_s1;
	logic [31:0]                  period_s1;
	logic [31:0]                  now_s1;
	logic [ptt_pkg::SLOT_W-1:0]   scan_q;
	logic [31:0]                  least_q;
	logic                         flag_q;
	logic                         m_tvalid_q;
	logic [ptt_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic [1:0]                   in_op;
	logic [2:0]                   in_slot;
	logic [31:0]                  in_period;
	logic [31:0]                  in_tick;
	logic [ptt_pkg::SLOT_W-1:0]   in_idx;
	logic                         in_ok;
	logic                         s_accept;
	logic                         out_free;
	logic                         scan_last;
	logic [ptt_pkg::SLOT_W-1:0]   rd_addr;
	ptt_pkg::slot_t               rd_entry;
	ptt_pkg::wr_req_t             wr;
	ptt_pkg::clr_req_t            clr;
	logic [31:0]                  per_sel;
	logic [31:0]                  deadline;
	logic                         expired;
	logic [31:0]                  left;

	// Input unpacking
	assign in_op     = s_tdata[1:0];
	assign in_slot   = s_tdata[4:2];
	assign in_period = s_tdata[36:5];
	assign in_tick   = s_tdata[68:37];
	assign in_idx    = ptt_pkg::SLOT_W'(in_slot);
	assign in_ok     = 32'(in_slot) < 32'(ptt_pkg::SLOT_COUNT);

	// Handshakes
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Table read address: polled slot or slot 0 on acceptance, then the scan
	assign scan_last = (scan_q == ptt_pkg::SLOT_W'(ptt_pkg::SLOT_COUNT - 1));
	always_comb begin
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_op == ptt_pkg::OP_POLL && in_ok) rd_addr = in_idx;
			end
			ST_SCAN: begin
				if (!scan_last) rd_addr = ptt_pkg::SLOT_W'(scan_q + 1'b1);
			end
			default: rd_addr = '0;
		endcase
	end

	// Expiry: poll checks against the newly stored period
	assign per_sel  = (state_q == ST_POLL) ? period_s1 : rd_entry.period;
	assign deadline = rd_entry.start + per_sel;
	assign expired  = now_s1 > deadline;
	assign left     = deadline - now_s1;

	// Poll write-back
	always_comb begin
		wr.en           = (state_q == ST_POLL) && slot_ok_s1;
		wr.addr         = slot_idx_s1;
		wr.entry.start  = expired ? now_s1 : rd_entry.start;
		wr.entry.period = period_s1;
		wr.entry.used   = 1'b1;
	end

	// Init restarts the whole table at acceptance
	assign clr.en   = s_accept && (in_op == ptt_pkg::OP_INIT);
	assign clr.tick = in_tick;

	ptt_slot_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.wr       (wr),
		.clr      (clr)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_idx_s1 <= '0;
			slot_ok_s1  <= 1'b0;
			period_s1   <= '0;
			now_s1      <= '0;
			scan_q      <= '0;
			least_q     <= '0;
			flag_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			// Output valid: set from the response step, cleared on handshake
			if (state_q == ST_RESP && out_free) m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						slot_idx_s1 <= in_idx;
						slot_ok_s1  <= in_ok;
						period_s1   <= in_period;
						now_s1      <= in_tick;
						scan_q      <= '0;
						flag_q      <= 1'b0;
						least_q     <= (in_op == ptt_pkg::OP_GET_MIN) ? ptt_pkg::NONE_USED : '0;
						case (in_op)
							ptt_pkg::OP_POLL: state_q <= ST_POLL;
							ptt_pkg::OP_GET_MIN: state_q <= ST_SCAN;
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_POLL: begin
					flag_q  <= slot_ok_s1 && expired;
					state_q <= ST_RESP;
				end
				ST_SCAN: begin
					// expired slot forces zero, which no later slot can undercut
					if (rd_entry.used) begin
						if (expired) least_q <= '0;
						else if (left < least_q) least_q <= left;
					end
					if (scan_last) state_q <= ST_RESP;
					else scan_q <= ptt_pkg::SLOT_W'(scan_q + 1'b1);
				end
				ST_RESP: begin
					if (out_free) begin
						m_tdata_q  <= {7'd0, least_q, flag_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks
	`PTT_ASSERT(a_one_at_a_time, s_accept |=> !s_tready, "transaction accepted while busy")
	`PTT_ASSERT(a_result_from_resp, $rose(m_tvalid) |-> $past(state_q == ST_RESP), "result not from response step")
	`PTT_ASSERT(a_zero_sticks, (state_q == ST_SCAN && least_q == '0) |=> (least_q == '0), "expired minimum lost")
	`PTT_ASSERT_ALWAYS(a_scan_in_range, (state_q == ST_SCAN) |-> (32'(scan_q) < 32'(ptt_pkg::SLOT_COUNT)), "scan index out of range")
	`PTT_ASSERT(a_write_only_valid_slot, wr.en |-> (slot_ok_s1 && state_q == ST_POLL), "write to unchecked slot")

endmodule

/* src/ptt_slot_store.sv */
// Slot table storage: synchronous memory with a registered read plus
// per-entry valid bits. Depends on ptt_pkg.
module ptt_slot_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ptt_pkg::SLOT_W-1:0] rd_addr,
	output ptt_pkg::slot_t            rd_entry,
	input  ptt_pkg::wr_req_t          wr,
	input  ptt_pkg::clr_req_t         clr
);

	ptt_pkg::slot_t                    mem_q [ptt_pkg::SLOT_COUNT];
	logic [ptt_pkg::SLOT_COUNT-1:0]    valid_q;
	logic [31:0]                       init_tick_q;
	ptt_pkg::slot_t                    rd_raw_s1;
	logic                              rd_valid_s1;

	// Memory array: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.entry;
		end
		rd_raw_s1 <= mem_q[rd_addr];
	end

	// Valid bits and restart tick; an invalid entry reads as freshly restarted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			init_tick_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= valid_q[rd_addr];
			if (clr.en) begin
				valid_q     <= '0;
				init_tick_q <= clr.tick;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
		end
	end

	// Read data with default substitution
	always_comb begin
		if (rd_valid_s1) begin
			rd_entry = rd_raw_s1;
		end else begin
			rd_entry.start  = init_tick_q;
			rd_entry.period = 32'd1;
			rd_entry.used   = 1'b0;
		end
	end

endmodule

/* tb/tb_periodic_timeout_table.sv */
// Self-checking testbench for periodic_timeout_table: directed and random timer commands
// are checked against an in-bench copy of the slot table, with random stalls on both sides.
// Depends on ptt_pkg and the periodic_timeout_table RTL.
`timescale 1ns / 100ps

module tb_periodic_timeout_table;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         RANDOM_CMDS = 1330;
	localparam int         LONG_HOLD   = 300;
	localparam int         STALL_LIMIT = 3000;
	localparam int         TAIL_CYCLES = 4 * ptt_pkg::SLOT_COUNT + 20;
	localparam int         MAX_REPORTS = 100;

	// One command on the input stream; gap and drain only shape the timing
	typedef struct {
		logic [1:0]  op;
		logic [2:0]  slot;
		logic [31:0] period;
		logic [31:0] tick;
		int          gap;
		bit          drain;
	} timer_cmd_t;

	// One reply on the output stream
	typedef struct {
		logic        timed_out;
		logic [31:0] min_left;
	} timer_reply_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [ptt_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [ptt_pkg::OUT_TDATA_W-1:0] m_tdata;

	// Mirror of the slot table
	logic [31:0] tbl_start  [ptt_pkg::SLOT_COUNT];
	logic [31:0] tbl_period [ptt_pkg::SLOT_COUNT];
	logic        tbl_used   [ptt_pkg::SLOT_COUNT];

	timer_cmd_t   cmd_q[$];
	timer_reply_t reply_due_q[$];
	timer_cmd_t   cur_cmd;
	int           cmds_total    = 0;
	int           cmds_accepted = 0;
	int           replies_seen  = 0;
	int           errors        = 0;
	int           stall_cycles  = 0;
	int           tx_gap_left   = 0;
	bit           tx_gap_loaded = 1'b0;
	bit           tx_quiet      = 1'b0;
	int           rx_hold_left  = 0;
	bit           rx_quiet      = 1'b0;
	bit           long_hold_done = 1'b0;

	periodic_timeout_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Slot has run past start + period (32-bit wrap, unsigned compare)
	function automatic bit slot_expired(input int idx, input logic [31:0] now);
		logic [31:0] deadline;
		deadline = tbl_start[idx] + tbl_period[idx];
		return now > deadline;
	endfunction

	// Apply one command to the mirror table and return the reply it owes
	function automatic timer_reply_t step_timer_table(input timer_cmd_t cmd);
		timer_reply_t rep;
		logic [31:0]  left;
		bit           any_expired;
		rep.timed_out = 1'b0;
		rep.min_left  = '0;
		any_expired   = 1'b0;
		case (cmd.op)
			ptt_pkg::OP_INIT: begin
				for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++) begin
					tbl_start[i]  = cmd.tick;
					tbl_period[i] = 32'd1;
					tbl_used[i]   = 1'b0;
				end
			end
			ptt_pkg::OP_POLL: begin
				if (int'(cmd.slot) < ptt_pkg::SLOT_COUNT) begin
					tbl_period[cmd.slot] = cmd.period;
					tbl_used[cmd.slot]   = 1'b1;
					if (slot_expired(int'(cmd.slot), cmd.tick)) begin
						tbl_start[cmd.slot] = cmd.tick;
						rep.timed_out       = 1'b1;
					end
				end
			end
			ptt_pkg::OP_GET_MIN: begin
				rep.min_left = ptt_pkg::NONE_USED;
				for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++) begin
					if (tbl_used[i]) begin
						if (slot_expired(i, cmd.tick))
							any_expired = 1'b1;
						left = tbl_period[i] - (cmd.tick - tbl_start[i]);
						if (left < rep.min_left)
							rep.min_left = left;
					end
				end
				if (any_expired)
					rep.min_left = '0;
			end
			default: ;
		endcase
		return rep;
	endfunction

	task automatic queue_cmd(input logic [1:0] op, input logic [2:0] slot,
			input logic [31:0] period, input logic [31:0] tick, input bit drain);
		timer_cmd_t cmd;
		cmd.op     = op;
		cmd.slot   = slot;
		cmd.period = period;
		cmd.tick   = tick;
		cmd.gap    = tx_quiet ? 0 : pick_gap();
		cmd.drain  = drain;
		cmd_q.push_back(cmd);
		cmds_total++;
	endtask

	// Input driver: predicts each accepted transaction, then offers the next command
	always @(posedge clk or negedge arst_n) begin
		bit offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				reply_due_q.push_back(step_timer_table(cur_cmd));
				cmds_accepted++;
				offer = 1'b0;
			end
			if (!offer && cmd_q.size() != 0) begin
				if (!tx_gap_loaded) begin
					tx_gap_left   = cmd_q[0].gap;
					tx_gap_loaded = 1'b1;
				end
				if (tx_gap_left > 0)
					tx_gap_left--;
				else if (!cmd_q[0].drain || reply_due_q.size() == 0) begin
					cur_cmd       = cmd_q.pop_front();
					tx_gap_loaded = 1'b0;
					offer         = 1'b1;
					s_tdata       <= {{(ptt_pkg::IN_TDATA_W - 69){1'b0}}, cur_cmd.tick,
						cur_cmd.period, cur_cmd.slot, cur_cmd.op};
				end
			end
			s_tvalid <= offer;
		end
	end

	// Output monitor: checks each reply transaction and throttles m_tready
	always @(posedge clk or negedge arst_n) begin
		timer_reply_t due;
		logic         got_flag;
		logic [31:0]  got_min;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_flag = m_tdata[0];
				got_min  = m_tdata[32:1];
				replies_seen++;
				if (replies_seen % 150 == 0)
					rx_quiet = ($urandom_range(0, 2) == 0);
				if (reply_due_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected reply, expected none, actual timed_out=%0b min_remaining=%h",
							$time, got_flag, got_min);
				end else begin
					due = reply_due_q.pop_front();
					if (got_flag !== due.timed_out) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: timed_out mismatch, expected %0b, actual %0b",
								$time, due.timed_out, got_flag);
					end
					if (got_min !== due.min_left) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: min_remaining mismatch, expected %h, actual %h",
								$time, due.min_left, got_min);
					end
				end
			end
			// Ready pattern: one long hold, quiet stretches, random stalls
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && replies_seen >= 500) begin
				long_hold_done = 1'b1;
				rx_hold_left   = LONG_HOLD - 1;
				m_tready       <= 1'b0;
			end else if (rx_quiet || $urandom_range(0, 99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				rx_hold_left = pick_gap();
				m_tready     <= 1'b0;
			end
		end
	end

	// Watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
	end

	initial begin
		logic [31:0] now;
		logic [1:0]  op;
		logic [31:0] period;
		int          r;

		for (int i = 0; i < ptt_pkg::SLOT_COUNT; i++) begin
			tbl_start[i]  = '0;
			tbl_period[i] = 32'd1;
			tbl_used[i]   = 1'b0;
		end

		// Directed: empty table, unknown op, boundary and wrapped deadlines
		queue_cmd(ptt_pkg::OP_GET_MIN, 3'd0, 32'd0, 32'd0, 1'b0);
		queue_cmd(OP_UNUSED, 3'd7, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		queue_cmd(ptt_pkg::OP_POLL, 3'd0, 32'd5, 32'd3, 1'b0);
		queue_cmd(ptt_pkg::OP_POLL, 3'd0, 32'd5, 32'd6, 1'b0);
		queue_cmd(ptt_pkg::OP_GET_MIN, 3'd0, 32'd0, 32'd8, 1'b0);
		queue_cmd(ptt_pkg::OP_POLL, 3'd7, 32'hffff_ffff, 32'd0, 1'b0);
		queue_cmd(ptt_pkg::OP_GET_MIN, 3'd0, 32'd0, 32'hffff_fffe, 1'b0);
		queue_cmd(ptt_pkg::OP_INIT, 3'd0, 32'd0, 32'hffff_ffff, 1'b0);
		queue_cmd(ptt_pkg::OP_GET_MIN, 3'd0, 32'd0, 32'd0, 1'b0);
		queue_cmd(ptt_pkg::OP_POLL, 3'd3, 32'd1, 32'd0, 1'b0);
		queue_cmd(ptt_pkg::OP_POLL, 3'd3, 32'd1, 32'd1, 1'b0);
		queue_cmd(ptt_pkg::OP_POLL, 3'd5, 32'd0, 32'hffff_ffff, 1'b0);
		queue_cmd(ptt_pkg::OP_GET_MIN, 3'd0, 32'd0, 32'd1, 1'b0);
		queue_cmd(ptt_pkg::OP_POLL, 3'd6, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		queue_cmd(ptt_pkg::OP_GET_MIN, 3'd0, 32'd0, 32'd0, 1'b0);
		queue_cmd(ptt_pkg::OP_POLL, 3'd1, 32'h8000_0000, 32'h5555_5555, 1'b0);
		queue_cmd(ptt_pkg::OP_POLL, 3'd2, 32'h7fff_ffff, 32'haaaa_aaaa, 1'b0);
		queue_cmd(ptt_pkg::OP_POLL, 3'd4, 32'd0, 32'h1234_5678, 1'b0);
		queue_cmd(ptt_pkg::OP_GET_MIN, 3'd0, 32'd0, 32'h1234_5679, 1'b0);
		queue_cmd(ptt_pkg::OP_INIT, 3'd0, 32'd0, 32'd0, 1'b1);
		queue_cmd(ptt_pkg::OP_GET_MIN, 3'd0, 32'd0, 32'd0, 1'b0);

		// Random: a slowly advancing tick with jumps and steps back, mostly polls
		now = $urandom;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 100 == 0)
				tx_quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 4)
				now = $urandom;
			else if (r < 10)
				now = now - $urandom_range(1, 12);
			else
				now = now + $urandom_range(0, 12);
			r = $urandom_range(0, 99);
			if (r < 70)
				period = $urandom_range(0, 20);
			else if (r < 78)
				period = '0;
			else if (r < 89)
				period = $urandom;
			else
				period = 32'hffff_ffff - $urandom_range(0, 20);
			r = $urandom_range(0, 99);
			if (r < 3)
				op = ptt_pkg::OP_INIT;
			else if (r < 6)
				op = OP_UNUSED;
			else if (r < 28)
				op = ptt_pkg::OP_GET_MIN;
			else
				op = ptt_pkg::OP_POLL;
			queue_cmd(op, 3'($urandom_range(0, 7)), period, now,
				n == 700 || $urandom_range(0, 199) == 0);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!(cmds_accepted == cmds_total && reply_due_q.size() == 0)
				&& stall_cycles < STALL_LIMIT)
			@(posedge clk);
		if (stall_cycles < STALL_LIMIT)
			repeat (TAIL_CYCLES) @(posedge clk);

		if (stall_cycles < STALL_LIMIT && errors == 0 && reply_due_q.size() == 0) begin
			$display("[periodic_timeout_table] OK");
		end else begin
			if (reply_due_q.size() != 0)
				$display("%0t: %0d replies still outstanding", $time, reply_due_q.size());
			$display("[periodic_timeout_table] ERROR");
		end
		$finish;
	end

endmodule
